// ===== rtl/core/acju_pkg.sv =====
// ----------------------------------------------------------------------------
// acju_pkg: shared types and constants of the compare / jump execution unit
// command codes, word width and the bit layout of the stream items
// ----------------------------------------------------------------------------
package acju_pkg;

  localparam int WORD_W     = 16;
  localparam int CMD_W      = 5;
  localparam int STEP_W     = 4;   // bits of a shift amount / iteration index below WORD_W
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // result item layout inside out_tdata
  localparam int OUT_WR_BIT   = 16;
  localparam int OUT_FLAG_BIT = 17;
  localparam int OUT_JMP_BIT  = 18;
  localparam int OUT_TGT_LSB  = 19;
  localparam int OUT_TGT_MSB  = 34;
  localparam int OUT_DZ_BIT   = 35;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOP  = 5'd0,
    CMD_MOV  = 5'd1,
    CMD_ADD  = 5'd2,
    CMD_SUB  = 5'd3,
    CMD_MUL  = 5'd4,
    CMD_DIV  = 5'd5,
    CMD_NOT  = 5'd6,
    CMD_AND  = 5'd7,
    CMD_NAND = 5'd8,
    CMD_OR   = 5'd9,
    CMD_NOR  = 5'd10,
    CMD_XOR  = 5'd11,
    CMD_XNOR = 5'd12,
    CMD_SHL  = 5'd13,
    CMD_SHR  = 5'd14,
    CMD_JMP  = 5'd15,
    CMD_JZ   = 5'd16,
    CMD_JNZ  = 5'd17,
    CMD_EQ   = 5'd18,
    CMD_NE   = 5'd19,
    CMD_GTU  = 5'd20,
    CMD_GEU  = 5'd21,
    CMD_LTU  = 5'd22,
    CMD_LEU  = 5'd23,
    CMD_GTS  = 5'd24,
    CMD_GES  = 5'd25,
    CMD_LTS  = 5'd26,
    CMD_LES  = 5'd27,
    CMD_IMM  = 5'd28
  } cmd_t;

endpackage

// ===== rtl/core/alu_compare_jump_unit_16bit.sv =====
// ----------------------------------------------------------------------------
// alu_compare_jump_unit_16bit: execution unit of a 16-bit toy machine
// results: an item is accepted in idle and its result is registered in exec, which
//   waits while the output stalls; mul and div first pass through the shared adder in iter, once per operand bit
// pacing: no new item is taken until the last result is registered; for mul and div
//   the radix-2 shift-add / shift-subtract loop over the one 17-bit adder sets the pace
// reset: synchronous active-low rst_n clears the sequencer, output valid and compare flag
// ----------------------------------------------------------------------------
module alu_compare_jump_unit_16bit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [acju_pkg::IN_DATA_W-1:0]  in_tdata,   // operand_a [15:0], operand_b [31:16]
  input  logic [acju_pkg::CMD_W-1:0]      in_tuser,   // command [4:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [acju_pkg::OUT_DATA_W-1:0] out_tdata   // result_value [15:0], writes_result [16],
                                                      // compare_flag [17], jump_taken [18],
                                                      // jump_target [34:19],
                                                      // divide_by_zero [35], zero [39:36]
);

  localparam int W = acju_pkg::WORD_W;
  localparam logic [W-1:0] SIGN_MASK = {1'b1, {(W-1){1'b0}}};

  // idle waits for an item, iter runs mul/div steps, exec forms the result item
  typedef enum logic [1:0] {ST_IDLE, ST_ITER, ST_EXEC} state_t;

  state_t                         state_r;
  logic [acju_pkg::CMD_W-1:0]     cmd_r;
  logic [W-1:0]                   a_r;      // operand a, multiplicand, quotient shifter
  logic [W-1:0]                   b_r;      // operand b, multiplier shifter, divisor
  logic [W-1:0]                   acc_r;    // product accumulator or partial remainder
  logic [acju_pkg::STEP_W-1:0]    cnt_r;    // iteration steps left after the current one
  logic                           flag_r;   // stored compare flag
  logic                           out_valid_r;
  logic [acju_pkg::OUT_DATA_W-1:0] out_data_r;

  // shared adder / subtractor, one bit wider than the word for the divide trial
  logic [W:0]   add_x;
  logic [W:0]   add_y;
  logic         add_sub;
  logic [W+1:0] add_sum;
  logic         add_carry;   // on subtract: x >= y

  logic [W-1:0]                    res_val;
  logic                            res_wr;
  logic                            res_jmp;
  logic                            res_dz;
  logic                            flag_nxt;
  logic                            ops_eq;
  logic                            long_shift;
  logic                            out_free;
  logic [acju_pkg::OUT_DATA_W-1:0] out_pack;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // adder operand selection
  always_comb begin
    add_x   = {1'b0, a_r};
    add_y   = {1'b0, b_r};
    add_sub = 1'b1;
    if (state_r == ST_ITER) begin
      if (cmd_r == acju_pkg::CMD_MUL) begin
        add_x   = {1'b0, acc_r};
        add_y   = {1'b0, a_r};
        add_sub = 1'b0;
      end else begin
        // divide trial: shifted remainder with next dividend bit
        add_x = {acc_r, a_r[W-1]};
      end
    end else begin
      case (cmd_r)
        acju_pkg::CMD_ADD: add_sub = 1'b0;
        acju_pkg::CMD_GTS, acju_pkg::CMD_GES, acju_pkg::CMD_LTS, acju_pkg::CMD_LES: begin
          // offset form makes unsigned order match signed order
          add_x = {1'b0, a_r ^ SIGN_MASK};
          add_y = {1'b0, b_r ^ SIGN_MASK};
        end
        default: add_sub = 1'b1;
      endcase
    end
  end

  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+2)'(add_sub);
  assign add_carry = add_sum[W+1];

  assign ops_eq     = (a_r == b_r);
  assign long_shift = |b_r[W-1:acju_pkg::STEP_W];

  // result item of the command held in the operand registers
  always_comb begin
    res_val  = '0;
    res_wr   = 1'b0;
    res_jmp  = 1'b0;
    res_dz   = 1'b0;
    flag_nxt = flag_r;
    case (cmd_r)
      acju_pkg::CMD_MOV, acju_pkg::CMD_IMM: begin
        res_val = a_r;
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_ADD, acju_pkg::CMD_SUB: begin
        res_val = add_sum[W-1:0];
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_MUL: begin
        res_val = acc_r;
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_DIV: begin
        // a zero divisor leaves an all-ones quotient in the shifter
        res_val = a_r;
        res_wr  = 1'b1;
        res_dz  = (b_r == '0);
      end
      acju_pkg::CMD_NOT: begin
        res_val = ~a_r;
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_AND: begin
        res_val = a_r & b_r;
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_NAND: begin
        res_val = ~(a_r & b_r);
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_OR: begin
        res_val = a_r | b_r;
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_NOR: begin
        res_val = ~(a_r | b_r);
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_XOR: begin
        res_val = a_r ^ b_r;
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_XNOR: begin
        res_val = ~(a_r ^ b_r);
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_SHL: begin
        res_val = long_shift ? '0 : (a_r << b_r[acju_pkg::STEP_W-1:0]);
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_SHR: begin
        res_val = long_shift ? '0 : (a_r >> b_r[acju_pkg::STEP_W-1:0]);
        res_wr  = 1'b1;
      end
      acju_pkg::CMD_JMP: res_jmp = 1'b1;
      acju_pkg::CMD_JZ:  res_jmp = !flag_r;
      acju_pkg::CMD_JNZ: res_jmp = flag_r;
      acju_pkg::CMD_EQ:  flag_nxt = ops_eq;
      acju_pkg::CMD_NE:  flag_nxt = !ops_eq;
      acju_pkg::CMD_GTU, acju_pkg::CMD_GTS: flag_nxt = add_carry && !ops_eq;
      acju_pkg::CMD_GEU, acju_pkg::CMD_GES: flag_nxt = add_carry;
      acju_pkg::CMD_LTU, acju_pkg::CMD_LTS: flag_nxt = !add_carry;
      acju_pkg::CMD_LEU, acju_pkg::CMD_LES: flag_nxt = !add_carry || ops_eq;
      default: flag_nxt = flag_r;   // nop and unused codes
    endcase
  end

  // pack the result item
  always_comb begin
    out_pack                                              = '0;
    out_pack[W-1:0]                                       = res_val;
    out_pack[acju_pkg::OUT_WR_BIT]                        = res_wr;
    out_pack[acju_pkg::OUT_FLAG_BIT]                      = flag_nxt;
    out_pack[acju_pkg::OUT_JMP_BIT]                       = res_jmp;
    out_pack[acju_pkg::OUT_TGT_MSB:acju_pkg::OUT_TGT_LSB] = res_jmp ? a_r : '0;
    out_pack[acju_pkg::OUT_DZ_BIT]                        = res_dz;
  end

  // sequencer, operand registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in exec a ready receiver always lets the next item in
      if (out_tready && state_r != ST_EXEC) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r <= in_tuser;
            a_r   <= in_tdata[W-1:0];
            b_r   <= in_tdata[2*W-1:W];
            acc_r <= '0;
            cnt_r <= acju_pkg::STEP_W'(W - 1);
            if (in_tuser == acju_pkg::CMD_MUL || in_tuser == acju_pkg::CMD_DIV) begin
              state_r <= ST_ITER;
            end else begin
              state_r <= ST_EXEC;
            end
          end
        end
        ST_ITER: begin
          if (cmd_r == acju_pkg::CMD_MUL) begin
            // shift-add, one multiplier bit a step
            if (b_r[0]) begin
              acc_r <= add_sum[W-1:0];
            end
            a_r <= a_r << 1;
            b_r <= b_r >> 1;
          end else begin
            // restoring divide, one quotient bit a step
            acc_r <= add_carry ? add_sum[W-1:0] : add_x[W-1:0];
            a_r   <= {a_r[W-2:0], add_carry};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            out_data_r  <= out_pack;
            out_valid_r <= 1'b1;
            flag_r      <= flag_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/acju_checker.sv =====
// ----------------------------------------------------------------------------
// acju_checker: port-level checks of the execution unit
// watches the item handshakes and the consistency of result items
// ----------------------------------------------------------------------------
module acju_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [acju_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int W = acju_pkg::WORD_W;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // no write means a zero value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[acju_pkg::OUT_WR_BIT] |-> out_tdata[W-1:0] == '0)
    else $error("value without write");

  // no jump means a zero target
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[acju_pkg::OUT_JMP_BIT]
      |-> out_tdata[acju_pkg::OUT_TGT_MSB:acju_pkg::OUT_TGT_LSB] == '0)
    else $error("target without jump");

  // divide by zero writes all ones
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[acju_pkg::OUT_DZ_BIT]
      |-> out_tdata[acju_pkg::OUT_WR_BIT] && (&out_tdata[W-1:0]))
    else $error("bad divide-by-zero item");

endmodule

bind alu_compare_jump_unit_16bit acju_checker u_acju_checker (.*);

// ===== bench/acju_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acju_result_checker: result predictor and scoreboard of the execution unit
// follows the compare flag, predicts one result per accepted command and
// checks every delivered result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module acju_result_checker
  import acju_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              writes;
    logic              flag;
    logic              jump;
    logic [WORD_W-1:0] target;
    logic              dz;
  } exec_result_t;

  exec_result_t predicted_results[$];
  exec_result_t want;
  exec_result_t got;
  logic         flag_q;
  int           results_seen;

  // what the unit must deliver for one command, given the flag before it
  function automatic exec_result_t execute_command(input logic [CMD_W-1:0]  cmd,
                                                   input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b,
                                                   input logic              flag_in);
    exec_result_t r;
    r      = '0;
    r.flag = flag_in;
    case (cmd)
      CMD_MOV, CMD_IMM: begin r.value = a;          r.writes = 1'b1; end
      CMD_ADD:  begin r.value = a + b;              r.writes = 1'b1; end
      CMD_SUB:  begin r.value = a - b;              r.writes = 1'b1; end
      CMD_MUL:  begin r.value = a * b;              r.writes = 1'b1; end
      CMD_DIV: begin
        r.writes = 1'b1;
        if (b == '0) begin
          r.value = '1;
          r.dz    = 1'b1;
        end else begin
          r.value = a / b;
        end
      end
      CMD_NOT:  begin r.value = ~a;                 r.writes = 1'b1; end
      CMD_AND:  begin r.value = a & b;              r.writes = 1'b1; end
      CMD_NAND: begin r.value = ~(a & b);           r.writes = 1'b1; end
      CMD_OR:   begin r.value = a | b;              r.writes = 1'b1; end
      CMD_NOR:  begin r.value = ~(a | b);           r.writes = 1'b1; end
      CMD_XOR:  begin r.value = a ^ b;              r.writes = 1'b1; end
      CMD_XNOR: begin r.value = ~(a ^ b);           r.writes = 1'b1; end
      CMD_SHL: begin
        r.writes = 1'b1;
        r.value  = (b >= WORD_W) ? '0 : (a << b[STEP_W-1:0]);
      end
      CMD_SHR: begin
        r.writes = 1'b1;
        r.value  = (b >= WORD_W) ? '0 : (a >> b[STEP_W-1:0]);
      end
      CMD_JMP:  r.jump = 1'b1;
      CMD_JZ:   r.jump = ~flag_in;
      CMD_JNZ:  r.jump = flag_in;
      CMD_EQ:   r.flag = (a == b);
      CMD_NE:   r.flag = (a != b);
      CMD_GTU:  r.flag = (a > b);
      CMD_GEU:  r.flag = (a >= b);
      CMD_LTU:  r.flag = (a < b);
      CMD_LEU:  r.flag = (a <= b);
      CMD_GTS:  r.flag = ($signed(a) > $signed(b));
      CMD_GES:  r.flag = ($signed(a) >= $signed(b));
      CMD_LTS:  r.flag = ($signed(a) < $signed(b));
      CMD_LES:  r.flag = ($signed(a) <= $signed(b));
      default: ;  // nop and unused codes leave everything alone
    endcase
    if (r.jump) r.target = a;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got_v,
                                 input logic [WORD_W-1:0] want_v);
    fail_count++;
    $display("mismatch on %s at result %0d: got %h, expected %h",
             field, results_seen, got_v, want_v);
  endtask

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    flag_q       = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      predicted_results.delete();
      flag_q = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.value  = out_tdata[WORD_W-1:0];
        got.writes = out_tdata[OUT_WR_BIT];
        got.flag   = out_tdata[OUT_FLAG_BIT];
        got.jump   = out_tdata[OUT_JMP_BIT];
        got.target = out_tdata[OUT_TGT_MSB:OUT_TGT_LSB];
        got.dz     = out_tdata[OUT_DZ_BIT];
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing pending", got.value, '0);
        end else begin
          want = predicted_results.pop_front();
          if (got.value !== want.value)   report_mismatch("result_value", got.value, want.value);
          if (got.writes !== want.writes) report_mismatch("writes_result", got.writes, want.writes);
          if (got.flag !== want.flag)     report_mismatch("compare_flag", got.flag, want.flag);
          if (got.jump !== want.jump)     report_mismatch("jump_taken", got.jump, want.jump);
          if (got.target !== want.target) report_mismatch("jump_target", got.target, want.target);
          if (got.dz !== want.dz)         report_mismatch("divide_by_zero", got.dz, want.dz);
          if (out_tdata[OUT_DATA_W-1:OUT_DZ_BIT+1] !== '0)
            report_mismatch("pad bits", out_tdata[OUT_DATA_W-1:OUT_DZ_BIT+1], '0);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        want   = execute_command(in_tuser, in_tdata[WORD_W-1:0],
                                 in_tdata[2*WORD_W-1:WORD_W], flag_q);
        flag_q = want.flag;
        predicted_results.push_back(want);
      end
    end
    pending = predicted_results.size();
  end

endmodule

// ===== bench/alu_compare_jump_unit_16bit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_compare_jump_unit_16bit_tb: stream-level test of the execution unit
// a directed pass over most commands and corner cases, then random commands
// with compare / conditional-jump pairs, random gaps on both channels and one
// long output hold; the checker module predicts and compares each result
// ----------------------------------------------------------------------------
module alu_compare_jump_unit_16bit_tb;
  import acju_pkg::*;

  localparam int RANDOM_ITEMS     = 1400;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PRESSURE_ITEMS   = 40;

  // command codes the unit decodes as nop
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 5'd29;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 5'd31;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  logic hold_req    = 1'b0;  // raised by stimulus, served once by the receiver
  logic hold_done   = 1'b0;
  logic steady      = 1'b0;  // no receiver stalls while set

  always #2 clk = ~clk;

  alu_compare_jump_unit_16bit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  acju_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (mismatches),
    .pending    (outstanding)
  );

  // mostly short idles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // operand biased toward the word extremes and small values
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return WORD_W'($urandom_range(0, 20));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // second operand shaped by the command: shift amounts near the word width,
  // zero divisors now and then, equal operands for compares
  function automatic logic [WORD_W-1:0] pick_operand_b(input logic [CMD_W-1:0] cmd,
                                                       input logic [WORD_W-1:0] a);
    if (cmd == CMD_SHL || cmd == CMD_SHR)
      return ($urandom_range(0, 3) == 0) ? pick_word()
                                         : WORD_W'($urandom_range(0, WORD_W + 1));
    if (cmd == CMD_DIV && $urandom_range(0, 4) == 0)
      return '0;
    if (cmd >= CMD_EQ && cmd <= CMD_LES && $urandom_range(0, 3) == 0)
      return a;
    return pick_word();
  endfunction

  // offer one item after an optional idle, return once it is accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // compare followed by a jump that reads the fresh flag
  task automatic send_compare_jump(input int gap);
    logic [CMD_W-1:0]  cmp;
    logic [CMD_W-1:0]  jmp;
    logic [WORD_W-1:0] a;
    cmp = CMD_W'(CMD_EQ + $urandom_range(0, CMD_LES - CMD_EQ));
    a   = pick_word();
    send_item(cmp, a, pick_operand_b(cmp, a), gap);
    case ($urandom_range(0, 4))
      0:       jmp = CMD_JMP;
      1, 2:    jmp = CMD_JZ;
      default: jmp = CMD_JNZ;
    endcase
    send_item(jmp, WORD_W'($urandom), WORD_W'($urandom),
              ($urandom_range(0, 2) == 0) ? pick_gap() : 0);
  endtask

  // receiver: random ready stretches and stalls, one long hold on request
  initial begin
    int stall;
    int run;
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = steady ? 0 : pick_gap();
        run   = $urandom_range(1, 24);
        if (stall > 0) begin
          @(negedge clk);
          out_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
        @(negedge clk);
        out_tready <= 1'b1;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int               n;
    logic [CMD_W-1:0] cmd;
    logic [WORD_W-1:0] a;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: most commands, operand extremes, divide by zero, long shifts,
    // taken and not-taken jumps, signed vs unsigned order, unused codes
    send_item(CMD_NOP,  16'hFFFF, 16'hFFFF, 0);
    send_item(CMD_MOV,  16'hFFFF, 16'h0000, 0);
    send_item(CMD_IMM,  16'h8001, 16'hFFFF, 1);
    send_item(CMD_ADD,  16'hFFFF, 16'h0001, 0);
    send_item(CMD_SUB,  16'h0000, 16'h0001, 0);
    send_item(CMD_MUL,  16'hFFFF, 16'hFFFF, 2);
    send_item(CMD_DIV,  16'h1234, 16'h0000, 0);
    send_item(CMD_DIV,  16'hFFFF, 16'h0001, 0);
    send_item(CMD_DIV,  16'h0007, 16'hFFFF, 0);
    send_item(CMD_NOT,  16'h0000, 16'h5555, 0);
    send_item(CMD_AND,  16'hF0F0, 16'hFF00, 0);
    send_item(CMD_NAND, 16'hFFFF, 16'hFFFF, 0);
    send_item(CMD_OR,   16'h0000, 16'h0000, 3);
    send_item(CMD_NOR,  16'h0000, 16'h0000, 0);
    send_item(CMD_XOR,  16'hAAAA, 16'h5555, 0);
    send_item(CMD_XNOR, 16'hAAAA, 16'hAAAA, 0);
    send_item(CMD_SHL,  16'h0001, 16'd15, 0);
    send_item(CMD_SHL,  16'hFFFF, 16'd16, 0);
    send_item(CMD_SHR,  16'h8000, 16'hFFFF, 0);
    send_item(CMD_SHR,  16'hFFFF, 16'd0, 0);
    send_item(CMD_JZ,   16'hFFFF, 16'h0000, 0);
    send_item(CMD_EQ,   16'h1234, 16'h1234, 0);
    send_item(CMD_JNZ,  16'h8000, 16'h0000, 0);
    send_item(CMD_JZ,   16'h4321, 16'h0000, 0);
    send_item(CMD_GTU,  16'h8000, 16'h7FFF, 0);
    send_item(CMD_GTS,  16'h8000, 16'h7FFF, 0);
    send_item(CMD_LES,  16'hFFFF, 16'h0000, 0);
    send_item(CMD_UNUSED_LAST, 16'hFFFF, 16'hFFFF, 0);
    send_item(CMD_JMP,  16'hFFFF, 16'h0000, 0);

    // random part: compare/jump pairs with random content, the rest any code
    n = 0;
    while (n < RANDOM_ITEMS) begin
      steady = ((n % 300) < 60);

      // long receiver hold while the sender keeps pushing back to back
      if (!hold_req && n >= RANDOM_ITEMS / 2) begin
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS) begin
          cmd = CMD_W'($urandom_range(CMD_NOP, CMD_UNUSED_LAST));
          a   = pick_word();
          send_item(cmd, a, pick_operand_b(cmd, a), 0);
        end
        n += PRESSURE_ITEMS;
      end

      if ($urandom_range(0, 99) < 35) begin
        send_compare_jump(steady ? 0 : pick_gap());
        n += 2;
      end else begin
        case ($urandom_range(0, 9))
          0:       cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
          1:       cmd = CMD_DIV;
          2:       cmd = CMD_W'($urandom_range(CMD_SHL, CMD_SHR));
          default: cmd = CMD_W'($urandom_range(CMD_NOP, CMD_IMM));
        endcase
        a = ($urandom_range(0, 1) == 0) ? pick_word() : WORD_W'($urandom);
        send_item(cmd, a, pick_operand_b(cmd, a), steady ? 0 : pick_gap());
        n++;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    steady = 1'b0;

    // drain, then give the unit time to show any stray result
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
